@@ hw/rtl/gamepad_mode_setup_and_stick_deadzone_core_assert.svh @@
// Assertion macros shared by the gamepad setup and deadzone core
`ifndef GAMEPAD_MODE_SETUP_AND_STICK_DEADZONE_CORE_ASSERT_SVH
`define GAMEPAD_MODE_SETUP_AND_STICK_DEADZONE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GMSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gmsd_pkg.sv @@
// Types, phase codes and constants for the gamepad setup and deadzone core
package gmsd_pkg;

  localparam int PhaseW = 3;
  localparam int AxisW  = 8;
  localparam int NumAxes = 4;

  localparam logic [PhaseW-1:0] PH_DETECT    = 3'd0;
  localparam logic [PhaseW-1:0] PH_STD_CHECK = 3'd1;
  localparam logic [PhaseW-1:0] PH_STD_SET   = 3'd2;
  localparam logic [PhaseW-1:0] PH_STD_WAIT  = 3'd3;
  localparam logic [PhaseW-1:0] PH_PRS_CHECK = 3'd4;
  localparam logic [PhaseW-1:0] PH_PRS_SET   = 3'd5;
  localparam logic [PhaseW-1:0] PH_PRS_WAIT  = 3'd6;
  localparam logic [PhaseW-1:0] PH_READY     = 3'd7;

  localparam logic [1:0] REQ_FAILED   = 2'd1;
  localparam logic [1:0] REQ_COMPLETE = 2'd2;

  localparam logic [7:0] ID_STANDARD = 8'd4;
  localparam logic [7:0] ID_PRESSURE = 8'd7;

  // raw byte limits of the deadzone: centre 128, -42..+42 reads as zero
  localparam logic [7:0] DZ_POS_FIRST = 8'd171;
  localparam logic [7:0] DZ_POS_BASE  = 8'd170;
  localparam logic [7:0] DZ_NEG_LAST  = 8'd85;
  localparam logic [7:0] DZ_NEG_BASE  = 8'd86;
  // 127/85 as a 20-bit fixed-point factor, rounded up
  localparam logic [20:0] SCALE_MUL = 21'd1566696;

  typedef struct packed {
    logic        port_stable;
    logic [7:0]  current_id;
    logic [7:0]  extended_id;
    logic        has_modes;
    logic        mode_set_accepted;
    logic [1:0]  request_state;
    logic        press_capable;
    logic        press_accepted;
    logic        read_ok;
    logic [15:0] button_bytes;
    logic [31:0] stick_bytes;
  } poll_t;

  typedef struct packed {
    logic [15:0]       buttons_pressed;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic [2:0]        setup_phase;
    logic [15:0]       previous_buttons;
  } report_t;

  typedef struct packed {
    logic show;
    logic capture;
  } seq_status_t;

endpackage

@@ hw/rtl/gamepad_mode_setup_and_stick_deadzone_core.sv @@
// Top level of the gamepad mode setup and stick deadzone core
// One poll beat in, one report beat out. A poll is taken every cycle when the
// output side keeps up: the sequencer and the four parallel axis lanes settle
// in the cycle of acceptance and the report is registered in the output
// register or skid. A two-entry output buffer (register plus skid) lets a new
// poll in while one report waits; in_stall rises only once both entries are
// full. Axes are zero and buttons_pressed is zero outside the ready phase or
// while the port is unstable; a failed report read keeps the last stick bytes.
module gamepad_mode_setup_and_stick_deadzone_core
  import gmsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  poll_t   in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output report_t out_data
);

  logic              accept;
  logic              pop;
  logic [2:0]        phase;
  logic [2:0]        phase_next;
  seq_status_t       status;
  logic [31:0]       held_sticks;
  logic [31:0]       held_sticks_next;
  logic [15:0]       last_buttons;
  logic [15:0]       buttons_next;
  logic signed [7:0] axes [NumAxes];
  report_t           result;
  logic              skid_valid;
  report_t           skid_data;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  gmsd_phase_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .poll       (in_data),
    .phase      (phase),
    .phase_next (phase_next),
    .status     (status)
  );

  assign held_sticks_next = status.capture ? in_data.stick_bytes : held_sticks;
  assign buttons_next     = status.capture ? ~in_data.button_bytes : 16'h0000;

  for (genvar i = 0; i < NumAxes; i++) begin : g_lane
    gmsd_axis_lane u_lane (
      .raw  (held_sticks_next[AxisW*(NumAxes-i)-1 -: AxisW]),
      .show (status.show),
      .axis (axes[i])
    );
  end

  // merge lane outputs into one report
  always_comb begin
    result.buttons_pressed  = buttons_next;
    result.right_x          = axes[0];
    result.right_y          = axes[1];
    result.left_x           = axes[2];
    result.left_y           = axes[3];
    result.setup_phase      = phase_next;
    result.previous_buttons = last_buttons;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_sticks  <= '0;
      last_buttons <= '0;
    end else if (accept) begin
      held_sticks  <= held_sticks_next;
      last_buttons <= buttons_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) out_data <= result;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= result;
      end
    end
  end

`include "gamepad_mode_setup_and_stick_deadzone_core_assert.svh"

  `GMSD_ASSERT_NOW(a_skid_behind_main, skid_valid, out_valid, "skid beat held with empty output")
  `GMSD_ASSERT_NOW(a_capture_ready, status.capture, phase == PH_READY, "capture outside ready")
  `GMSD_ASSERT_NEXT(a_sticks_held, accept && status.capture, held_sticks == $past(in_data.stick_bytes), "stick bytes not captured")

endmodule

@@ hw/rtl/gmsd_axis_lane.sv @@
// One stick axis lane: deadzone and 127/85 scaling of a raw byte
module gmsd_axis_lane
  import gmsd_pkg::*;
(
  input  logic [7:0]        raw,
  input  logic              show,
  output logic signed [7:0] axis
);

  logic [6:0]  mag;
  logic        neg;
  logic        live;
  logic [27:0] prod;
  logic [7:0]  quot;

  always_comb begin
    mag  = '0;
    neg  = 1'b0;
    live = 1'b0;
    if (raw >= DZ_POS_FIRST) begin
      mag  = 7'(raw - DZ_POS_BASE);
      live = 1'b1;
    end else if (raw <= DZ_NEG_LAST) begin
      mag  = 7'(DZ_NEG_BASE - raw);
      neg  = 1'b1;
      live = 1'b1;
    end
  end

  assign prod = 28'(mag) * 28'(SCALE_MUL);
  assign quot = prod[27:20];

  always_comb begin
    if (!show || !live) begin
      axis = '0;
    end else if (neg) begin
      axis = $signed(8'(~quot + 8'd1));
    end else begin
      axis = $signed(quot);
    end
  end

endmodule

@@ hw/rtl/gmsd_phase_seq.sv @@
// Detection and mode setup sequencer for one controller port
module gmsd_phase_seq
  import gmsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  poll_t       poll,
  output logic [2:0]  phase,
  output logic [2:0]  phase_next,
  output seq_status_t status
);

  logic [7:0] id;

  assign id = (poll.extended_id != 8'd0) ? poll.extended_id : poll.current_id;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_DETECT: begin
        if (poll.port_stable && poll.current_id != 8'd0) begin
          if (id == ID_STANDARD) begin
            phase_next = PH_STD_CHECK;
          end else if (id == ID_PRESSURE) begin
            phase_next = PH_PRS_CHECK;
          end else begin
            phase_next = PH_READY;
          end
        end
      end
      PH_STD_CHECK: begin
        if (!poll.has_modes) begin
          phase_next = PH_READY;
        end else begin
          phase_next = poll.mode_set_accepted ? PH_STD_WAIT : PH_STD_SET;
        end
      end
      PH_STD_SET: begin
        if (poll.mode_set_accepted) phase_next = PH_STD_WAIT;
      end
      PH_STD_WAIT: begin
        if (poll.request_state == REQ_FAILED) begin
          phase_next = PH_STD_SET;
        end else if (poll.request_state == REQ_COMPLETE) begin
          phase_next = PH_DETECT;
        end
      end
      PH_PRS_CHECK: begin
        phase_next = poll.press_capable ? PH_PRS_SET : PH_READY;
      end
      PH_PRS_SET: begin
        if (poll.press_accepted) phase_next = PH_PRS_WAIT;
      end
      PH_PRS_WAIT: begin
        if (poll.request_state == REQ_FAILED) begin
          phase_next = PH_PRS_SET;
        end else if (poll.request_state == REQ_COMPLETE) begin
          phase_next = PH_READY;
        end
      end
      PH_READY: begin
        phase_next = PH_READY;
      end
      default: begin
        phase_next = PH_DETECT;
      end
    endcase
  end

  assign status.show    = (phase == PH_READY) && poll.port_stable;
  assign status.capture = (phase == PH_READY) && poll.port_stable && poll.read_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DETECT;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

endmodule
